/* hdl/fit_partition_allocator_unit_macros.svh */
// Assertion macros for the allocator checker
`ifndef FIT_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
// implication checked every clock, ignored during reset
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared codes for the fit partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoFit  = 2'd1;
  localparam logic [1:0] StZero   = 2'd2;
  localparam logic [1:0] StFull   = 2'd3;

  localparam logic       OpAlloc  = 1'b0;
  localparam logic       OpFree   = 1'b1;

  localparam logic       CfgFit   = 1'b0;
  localparam logic       CfgMem   = 1'b1;

  localparam int unsigned FreedMax = 127;

  // address width and process count are fixed by the port widths
  localparam int unsigned AddrBits     = 16;
  localparam int unsigned MaxProcesses = 64;
endpackage
`default_nettype wire

/* hdl/fit_partition_allocator_unit.sv */
// ----------------------------------------------------------------------------
// fit_partition_allocator_unit
// Allocate: the table is searched for a fitting region, which is taken whole or split.
// Release: the table is scanned for the owner's regions, then merge passes run, each
// scanning the table once per free region; passes repeat until one merges nothing.
// One transaction at a time: busy stays high until the result; results never stall.
// Reset (async, active low) leaves one free region [0, 65536) with first fit;
// busy stays high after reset and after a memory_size write until entry 0 is written.
// ----------------------------------------------------------------------------
`default_nettype none
module fit_partition_allocator_unit #(
  parameter int unsigned TABLE_DEPTH   = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_wdata_i,
  input  wire logic        op_i,
  input  wire logic [5:0]  process_id_i,
  input  wire logic [16:0] request_size_i,
  output logic             result_valid_o,
  output logic [1:0]       status_o,
  output logic [15:0]      start_address_o,
  output logic [6:0]       freed_regions_o
);
  import fpa_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = AddrBits + 1;
  localparam logic [SW-1:0] Cap = SW'(1) << AddrBits;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [SW-1:0]       size;
    logic [5:0]          owner;
  } entry_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRCH  = 10'b0000000010,
    S_DEC   = 10'b0000000100,
    S_SLOT  = 10'b0000001000,
    S_FREE  = 10'b0000010000,
    S_MI    = 10'b0000100000,
    S_MIW   = 10'b0001000000,
    S_MJ    = 10'b0010000000,
    S_MWB   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  // payload memory; valid and free flags live in flops
  entry_t              mem [TABLE_DEPTH];
  entry_t              rd_q;
  logic [IW-1:0]       ra;
  logic                we;
  logic [IW-1:0]       wa;
  entry_t              wd;

  logic [TABLE_DEPTH-1:0] vld_q, vld_d, fre_q, fre_d;
  state_e   st_q, st_d;
  logic [1:0]  fit_q, fit_d;
  logic [SW-1:0] msz_q, msz_d;
  logic [IW:0]   cnt_q, cnt_d;
  logic [IW-1:0] prev_q, prev_d;
  logic          op_q, op_d;
  logic [5:0]    pid_q, pid_d;
  logic [SW-1:0] req_q, req_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] sel_q, sel_d;
  entry_t        sele_q, sele_d;
  logic [1:0]    sts_q, sts_d;
  logic [15:0]   adr_q, adr_d;
  logic [6:0]    frd_q, frd_d;
  logic [IW-1:0] mi_q, mi_d;
  entry_t        mie_q, mie_d;
  logic          chg_q, chg_d;
  logic          pend_q, pend_d;   // read outstanding
  logic          rv_q, rv_d;
  logic          init_q, init_d;   // entry 0 payload needs writing

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic [SW-1:0] msz_sat;
  assign msz_sat = (cfg_wdata_i > Cap) ? Cap : cfg_wdata_i;

  logic [IW-1:0] cidx;
  logic          cv, cf, better;
  assign cidx = prev_q;
  assign cv   = vld_q[cidx];
  assign cf   = fre_q[cidx];

  always_comb begin
    better = 1'b0;
    case (fit_q)
      FitBest:  better = (rd_q.size < sele_q.size) ||
                         (rd_q.size == sele_q.size && rd_q.start < sele_q.start);
      FitWorst: better = (rd_q.size > sele_q.size) ||
                         (rd_q.size == sele_q.size && rd_q.start < sele_q.start);
      default:  better = rd_q.start < sele_q.start;
    endcase
  end

  always_comb begin
    st_d = st_q; vld_d = vld_q; fre_d = fre_q; fit_d = fit_q; msz_d = msz_q;
    cnt_d = cnt_q; prev_d = prev_q; op_d = op_q; pid_d = pid_q; req_d = req_q;
    hit_d = hit_q; sel_d = sel_q; sele_d = sele_q; sts_d = sts_q; adr_d = adr_q;
    frd_d = frd_q; mi_d = mi_q; mie_d = mie_q; chg_d = chg_q; pend_d = 1'b0;
    rv_d = 1'b0; init_d = init_q;
    ra = cnt_q[IW-1:0]; we = 1'b0; wa = '0; wd = '0;

    unique case (st_q)
      S_IDLE: begin
        if (init_q) begin
          we = 1'b1; wa = '0; wd.start = '0; wd.size = msz_q; wd.owner = '0;
          init_d = 1'b0;
        end
        if (cfg_we_i) begin
          unique case (cfg_index_i)
            CfgFit: fit_d = cfg_wdata_i[1:0];
            CfgMem: begin
              msz_d = msz_sat;
              vld_d = '0; fre_d = '0;
              vld_d[0] = (msz_sat != '0); fre_d[0] = (msz_sat != '0);
              init_d = 1'b1;
            end
            default: ;
          endcase
        end else if (start && !init_q) begin
          op_d = op_i; pid_d = process_id_i; req_d = request_size_i;
          sts_d = StOk; adr_d = '0; frd_d = '0; hit_d = 1'b0; cnt_d = '0;
          if (op_i == OpAlloc) begin
            if (request_size_i == '0) begin sts_d = StZero; st_d = S_DONE; end
            else if (32'(process_id_i) >= MaxProcesses) begin
              sts_d = StNoFit; st_d = S_DONE;
            end else st_d = S_SRCH;
          end else begin
            if (32'(process_id_i) >= MaxProcesses) st_d = S_DONE;
            else st_d = S_FREE;
          end
        end
      end
      S_SRCH: begin
        // issue read cnt, evaluate read issued last cycle
        if (pend_q && cv && cf && rd_q.size >= req_q && (!hit_q || better)) begin
          hit_d = 1'b1; sel_d = prev_q; sele_d = rd_q;
        end
        if (cnt_q == (IW+1)'(TABLE_DEPTH)) st_d = S_DEC;
        else begin
          ra = cnt_q[IW-1:0]; prev_d = cnt_q[IW-1:0]; pend_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DEC: begin
        if (!hit_q) begin sts_d = StNoFit; st_d = S_DONE; end
        else if (sele_q.size == req_q) begin
          fre_d[sel_q] = 1'b0;
          we = 1'b1; wa = sel_q; wd = sele_q; wd.owner = pid_q;
          adr_d = 16'(sele_q.start); st_d = S_DONE;
        end else st_d = S_SLOT;
        cnt_d = '0;
      end
      S_SLOT: begin
        // lowest invalid entry from the flag flops, one per cycle
        if (cnt_q == (IW+1)'(TABLE_DEPTH)) begin sts_d = StFull; st_d = S_DONE; end
        else if (!vld_q[cnt_q[IW-1:0]]) begin
          vld_d[cnt_q[IW-1:0]] = 1'b1; fre_d[cnt_q[IW-1:0]] = 1'b0;
          we = 1'b1; wa = cnt_q[IW-1:0];
          wd.start = sele_q.start; wd.size = req_q; wd.owner = pid_q;
          adr_d = 16'(sele_q.start);
          sele_d.start = sele_q.start + req_q[AddrBits-1:0];
          sele_d.size  = sele_q.size - req_q;
          st_d = S_MWB; // write back split remainder
        end else cnt_d = cnt_q + 1'b1;
      end
      S_MWB: begin
        we = 1'b1;
        if (op_q == OpAlloc) begin
          wa = sel_q; wd = sele_q; st_d = S_DONE;
        end else begin
          wa = mi_q; wd = mie_q; st_d = S_MI; ra = mi_q;
        end
      end
      S_FREE: begin
        if (pend_q && cv && !cf && rd_q.owner == pid_q) begin
          fre_d[prev_q] = 1'b1;
          we = 1'b1; wa = prev_q; wd = rd_q; wd.owner = '0;
          if (frd_q != 7'(FreedMax)) frd_d = frd_q + 1'b1;
        end
        if (cnt_q == (IW+1)'(TABLE_DEPTH)) begin
          cnt_d = '0; mi_d = '0; chg_d = 1'b0; st_d = S_MI;
        end else begin
          ra = cnt_q[IW-1:0]; prev_d = cnt_q[IW-1:0]; pend_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MI: begin
        // pick outer entry i; read it
        if (vld_q[mi_q] && fre_q[mi_q]) begin
          ra = mi_q; st_d = S_MIW;
        end else if (mi_q == IW'(TABLE_DEPTH-1)) begin
          if (chg_q) begin mi_d = '0; chg_d = 1'b0; end
          else st_d = S_DONE;
        end else mi_d = mi_q + 1'b1;
      end
      S_MIW: begin
        mie_d = rd_q; cnt_d = '0; st_d = S_MJ;
      end
      S_MJ: begin
        // absorb a free entry that starts where the outer region ends
        if (pend_q && prev_q != mi_q && cv && cf &&
            (SW'(mie_q.start) + mie_q.size) == SW'(rd_q.start)) begin
          mie_d.size = mie_q.size + rd_q.size;
          vld_d[prev_q] = 1'b0; fre_d[prev_q] = 1'b0; chg_d = 1'b1;
        end
        if (cnt_q == (IW+1)'(TABLE_DEPTH)) begin
          st_d = S_MWB;
        end else begin
          ra = cnt_q[IW-1:0]; prev_d = cnt_q[IW-1:0]; pend_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        if (st_d == S_MWB && mi_q != IW'(TABLE_DEPTH-1)) mi_d = mi_q;
      end
      S_DONE: begin
        rv_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase

    // after merge write-back advance outer index, or at the last entry restart or finish
    if (st_q == S_MWB && op_q == OpFree) begin
      if (mi_q == IW'(TABLE_DEPTH-1)) begin
        if (chg_q) begin mi_d = '0; chg_d = 1'b0; end
        else st_d = S_DONE;
      end else mi_d = mi_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; vld_q <= TABLE_DEPTH'(1); fre_q <= TABLE_DEPTH'(1);
      fit_q <= FitFirst; msz_q <= Cap; cnt_q <= '0; pend_q <= 1'b0;
      rv_q <= 1'b0; init_q <= 1'b1; chg_q <= 1'b0; mi_q <= '0; hit_q <= 1'b0;
    end else begin
      st_q <= st_d; vld_q <= vld_d; fre_q <= fre_d; fit_q <= fit_d; msz_q <= msz_d;
      cnt_q <= cnt_d; pend_q <= pend_d; rv_q <= rv_d; init_q <= init_d;
      chg_q <= chg_d; mi_q <= mi_d; hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d; op_q <= op_d; pid_q <= pid_d; req_q <= req_d;
    sel_q <= sel_d; sele_q <= sele_d; sts_q <= sts_d; adr_q <= adr_d;
    frd_q <= frd_d; mie_q <= mie_d;
  end

  assign busy            = (st_q != S_IDLE) || init_q;
  assign result_valid_o  = rv_q;
  assign status_o        = sts_q;
  assign start_address_o = adr_q;
  assign freed_regions_o = frd_q;
endmodule
`default_nettype wire

/* hdl/fpa_checker.sv */
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the allocator's command interface.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fit_partition_allocator_unit_macros.svh"
module fpa_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid_o,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] start_address_o,
  input wire logic [6:0]  freed_regions_o
);
  import fpa_pkg::*;
  `FPA_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "no busy after accept")
  `FPA_ASSERT_IMP(a_addr_zero, clk_i, rst_ni, result_valid_o && status_o != StOk,
    start_address_o == '0, "address not zero on error")
  `FPA_ASSERT_IMP(a_err_nofree, clk_i, rst_ni, result_valid_o && status_o != StOk,
    freed_regions_o == '0, "freed count on error")
  `FPA_ASSERT_NXT(a_single_strobe, clk_i, rst_ni, result_valid_o, !result_valid_o,
    "result strobe longer than one cycle")
endmodule
bind fit_partition_allocator_unit fpa_port_checker u_fpa_checker (.*);
`default_nettype wire

/* sim/fpa_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpa_checker
// Watches the request, register and result ports of the partition allocator.
// It keeps its own copy of the region table, predicts the status, start
// address and freed count of every accepted request, and compares them.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_wdata_i,
  input  wire logic        op_i,
  input  wire logic [5:0]  process_id_i,
  input  wire logic [16:0] request_size_i,
  input  wire logic        result_valid_o,
  input  wire logic [1:0]  status_o,
  input  wire logic [15:0] start_address_o,
  input  wire logic [6:0]  freed_regions_o,
  output int               fail_count_o
);
  import fpa_pkg::*;

  localparam int Depth = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [6:0]  freed;
  } alloc_result_t;

  alloc_result_t expected_q[$];

  logic [1:0]  fit_mode;
  logic [17:0] rg_start [Depth];
  logic [17:0] rg_size  [Depth];
  logic [5:0]  rg_owner [Depth];
  bit          rg_free  [Depth];
  bit          rg_valid [Depth];

  function automatic void rebuild_table(input logic [16:0] total);
    logic [17:0] cap;
    cap = (total > 17'd65536) ? 18'd65536 : {1'b0, total};
    for (int i = 0; i < Depth; i++) begin
      rg_start[i] = '0;
      rg_size[i]  = '0;
      rg_owner[i] = '0;
      rg_free[i]  = 1'b0;
      rg_valid[i] = 1'b0;
    end
    if (cap != 0) begin
      rg_size[0]  = cap;
      rg_free[0]  = 1'b1;
      rg_valid[0] = 1'b1;
    end
  endfunction

  function automatic void coalesce_free();
    bit changed;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < Depth; i++) begin
        if (rg_valid[i] && rg_free[i]) begin
          for (int j = 0; j < Depth; j++) begin
            if (j != i && rg_valid[j] && rg_free[j] &&
                rg_start[i] + rg_size[i] == rg_start[j]) begin
              rg_size[i] += rg_size[j];
              rg_valid[j] = 1'b0;
              rg_free[j]  = 1'b0;
              rg_start[j] = '0;
              rg_size[j]  = '0;
              rg_owner[j] = '0;
              changed = 1'b1;
            end
          end
        end
      end
    end
  endfunction

  function automatic alloc_result_t place_request(input logic op, input logic [5:0] pid,
                                                  input logic [16:0] req);
    alloc_result_t res;
    int sel;
    int slot;
    logic [17:0] want;
    res  = '{status: StOk, addr: '0, freed: '0};
    sel  = -1;
    slot = -1;
    want = {1'b0, req};
    if (op == OpAlloc) begin
      if (req == 0) begin
        res.status = StZero;
      end else begin
        for (int i = 0; i < Depth; i++) begin
          if (rg_valid[i] && rg_free[i] && rg_size[i] >= want) begin
            if (sel < 0) begin
              sel = i;
            end else if (fit_mode == FitBest) begin
              if (rg_size[i] < rg_size[sel] ||
                  (rg_size[i] == rg_size[sel] && rg_start[i] < rg_start[sel]))
                sel = i;
            end else if (fit_mode == FitWorst) begin
              if (rg_size[i] > rg_size[sel] ||
                  (rg_size[i] == rg_size[sel] && rg_start[i] < rg_start[sel]))
                sel = i;
            end else if (rg_start[i] < rg_start[sel]) begin
              sel = i;
            end
          end
        end
        if (sel < 0) begin
          res.status = StNoFit;
        end else if (rg_size[sel] == want) begin
          rg_free[sel]  = 1'b0;
          rg_owner[sel] = pid;
          res.addr = rg_start[sel][15:0];
        end else begin
          for (int i = 0; i < Depth; i++) begin
            if (slot < 0 && !rg_valid[i]) slot = i;
          end
          if (slot < 0) begin
            res.status = StFull;
          end else begin
            rg_valid[slot] = 1'b1;
            rg_free[slot]  = 1'b0;
            rg_owner[slot] = pid;
            rg_start[slot] = rg_start[sel];
            rg_size[slot]  = want;
            res.addr = rg_start[sel][15:0];
            rg_start[sel] += want;
            rg_size[sel]  -= want;
          end
        end
      end
    end else begin
      for (int i = 0; i < Depth; i++) begin
        if (rg_valid[i] && !rg_free[i] && rg_owner[i] == pid) begin
          rg_free[i]  = 1'b1;
          rg_owner[i] = '0;
          if (res.freed < FreedMax) res.freed++;
        end
      end
      coalesce_free();
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t exp_r;
    if (!rst_ni) begin
      fit_mode = FitFirst;
      rebuild_table(17'd65536);
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgFit) fit_mode = cfg_wdata_i[1:0];
        else rebuild_table(cfg_wdata_i);
      end
      if (start && !busy)
        expected_q = {expected_q, place_request(op_i, process_id_i, request_size_i)};
      if (result_valid_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d addr=%0d freed=%0d", $time,
                   status_o, start_address_o, freed_regions_o);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (status_o !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
            fail_count_o++;
          end
          if (start_address_o !== exp_r.addr) begin
            $display("%0t: start_address expected %0d actual %0d", $time, exp_r.addr,
                     start_address_o);
            fail_count_o++;
          end
          if (freed_regions_o !== exp_r.freed) begin
            $display("%0t: freed_regions expected %0d actual %0d", $time, exp_r.freed,
                     freed_regions_o);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sim/tb_fit_partition_allocator_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fit_partition_allocator_unit
// Drives allocate and release requests into the partition allocator under
// every placement rule and a range of memory sizes, with random start gaps;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_fit_partition_allocator_unit;
  import fpa_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [16:0] cfg_wdata_i;
  logic        op_i;
  logic [5:0]  process_id_i;
  logic [16:0] request_size_i;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [15:0] start_address_o;
  logic [6:0]  freed_regions_o;
  int          fail_count;

  int          issued;
  int          completed;
  int          releases;
  bit          gaps_on;
  logic [16:0] mem_now;

  fit_partition_allocator_unit DUT (.*);

  fpa_checker u_checker (.*, .fail_count_o(fail_count));

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i)
    if (rst_ni && result_valid_o) completed++;

  task automatic issue(input logic op, input logic [5:0] pid, input logic [16:0] len);
    @(negedge clk_i);
    op_i           <= op;
    process_id_i   <= pid;
    request_size_i <= len;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    issued++;
    if (op == OpFree) releases++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (completed != issued || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CfgMem) mem_now = (val > 17'd65536) ? 17'd65536 : val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    int          r;
    logic [16:0] len;
    logic [16:0] lim;
    r   = $urandom_range(0, 99);
    lim = (mem_now < 17'd24) ? 17'd1 : 17'(mem_now / 17'd24);
    if (r < 3) len = '0;
    else if (r < 6) len = ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'($urandom);
    else if (r < 82) len = 17'($urandom_range(1, lim));
    else len = 17'($urandom_range(1, (mem_now == 0) ? 1 : mem_now));
    if ($urandom_range(0, 99) < 18) issue(OpFree, 6'($urandom), 17'($urandom));
    else issue(OpAlloc, 6'($urandom), len);
  endtask

  initial begin
    logic [16:0] mem_pick [7];
    mem_pick = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'd131071, 17'd4096, 17'd65537};
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgFit;
    cfg_wdata_i = '0;
    op_i = OpAlloc;
    process_id_i = '0;
    request_size_i = '0;
    issued = 0;
    completed = 0;
    releases = 0;
    gaps_on = 1'b1;
    mem_now = 17'd65536;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset table: whole memory, first fit
    issue(OpAlloc, 6'd0, 17'd0);
    issue(OpAlloc, 6'd63, 17'd65536);
    issue(OpAlloc, 6'd1, 17'd1);
    issue(OpFree, 6'd63, 17'h1FFFF);
    issue(OpFree, 6'd5, 17'd0);
    issue(OpAlloc, 6'd2, 17'h1FFFF);
    issue(OpAlloc, 6'd3, 17'd100);
    issue(OpAlloc, 6'd4, 17'd50);
    issue(OpAlloc, 6'd3, 17'd100);
    issue(OpFree, 6'd3, 17'd0);
    issue(OpAlloc, 6'd7, 17'd100);
    drain();
    reg_write(CfgFit, 17'(FitBest));
    issue(OpAlloc, 6'd8, 17'd60);
    issue(OpAlloc, 6'd9, 17'd40);
    drain();
    reg_write(CfgFit, 17'(FitWorst));
    issue(OpAlloc, 6'd10, 17'd10);
    issue(OpFree, 6'd4, 17'd0);
    drain();
    reg_write(CfgFit, 17'd3);
    reg_write(CfgMem, 17'd0);
    issue(OpAlloc, 6'd11, 17'd1);
    issue(OpFree, 6'd11, 17'd0);
    drain();
    reg_write(CfgMem, 17'h1FFFF);
    issue(OpAlloc, 6'd12, 17'd65536);
    issue(OpAlloc, 6'd13, 17'd1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      gaps_on = (ph < 8);
      reg_write(CfgFit, 17'($urandom_range(0, 3)));
      reg_write(CfgMem, (ph < 7) ? mem_pick[ph] : 17'($urandom_range(64, 70000)));
      repeat (183) random_request();
      drain();
    end

    $display("Ran %0d requests (%0d releases) over 10 register settings and all fit rules.",
             issued, releases);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #(64'd4_000_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
